// ===== hw/rtl/rrc_pkg.sv =====
// Shared widths, register and side codes, and item types for the ray/rectangle clipper.
`default_nettype none
package rrc_pkg;

    // Coordinate format: signed fixed point, CW bits with FRAC_BITS fraction bits
    localparam int CW        = 32;
    localparam int FRAC_BITS = 16;

    // Difference width (coordinate minus coordinate)
    localparam int RW = CW + 1;
    // Product width (coordinate times difference)
    localparam int PW = 2 * CW + 1;
    // Width of cross-product differences, their negation and the rounded dividend
    localparam int SW = PW + 2;
    // Quotient bits; the hit offset always stays inside the rectangle span
    localparam int QW = CW + 2;

    localparam int NSIDE = 4;

    // Register file addressing: 4-byte stride up to 32-bit data, else 8-byte
    localparam int ADDR_LSB = (CW > 32) ? 3 : 2;
    localparam int PAW      = ADDR_LSB + 2;

    // Register indexes
    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_RIGHT  = 2'd1;
    localparam logic [1:0] REG_BOTTOM = 2'd2;
    localparam logic [1:0] REG_TOP    = 2'd3;

    // Side codes, in test order
    localparam logic [1:0] SIDE_BOTTOM = 2'd0;
    localparam logic [1:0] SIDE_RIGHT  = 2'd1;
    localparam logic [1:0] SIDE_TOP    = 2'd2;
    localparam logic [1:0] SIDE_LEFT   = 2'd3;

    // Reset value 1.0
    localparam logic [CW-1:0] COORD_ONE = CW'(64'd1 << FRAC_BITS);

    // One ray as it travels through the front stages
    typedef struct packed {
        logic signed [CW-1:0] ox;
        logic signed [CW-1:0] oy;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
    } t_ray;

    // Side-band data that rides along the divider
    typedef struct packed {
        logic                 hit;
        logic [1:0]           side;
        logic                 neg;
        logic signed [CW-1:0] base;
        logic signed [CW-1:0] plane;
    } t_res_info;

endpackage
`default_nettype wire

// ===== hw/rtl/ray_rectangle_clip.sv =====
// Top level: pipelined ray against axis-aligned rectangle boundary intersection.
//
// Input channel (i_valid / o_stall) takes one ray per item: origin and direction,
// signed fixed point. Output channel (o_valid / i_stall) gives one result per ray:
// hit flag, hit point and side (0 bottom, 1 right, 2 top, 3 left); a miss gives zeros.
// The rectangle comes from four registers on the APB port (left, right, bottom, top at
// byte offsets 0, 4, 8, 12); write them only while no ray is in flight.
//
// The path from accept to o_valid runs through five stages of side tests
// (differences, 32x33 products, cross-product differences, range compares, side
// select), one stage that sets up the rounded division, one stage per quotient bit
// of the restoring divider (34), and the output register.
// Throughput is one ray per cycle while the receiver does not stall a waiting result.
//
// Synchronous active-low reset clears all valid bits and loads the rectangle
// 0..1.0 in both axes. When the receiver stalls a waiting result, the whole pipeline
// holds and o_stall rises; no item is dropped or repeated.
`default_nettype none
module ray_rectangle_clip
    import rrc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic signed [CW-1:0] i_origin_x,
    input  wire logic signed [CW-1:0] i_origin_y,
    input  wire logic signed [CW-1:0] i_dir_x,
    input  wire logic signed [CW-1:0] i_dir_y,

    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic                      o_hit,
    output logic signed [CW-1:0]      o_hit_x,
    output logic signed [CW-1:0]      o_hit_y,
    output logic [1:0]                o_hit_side,

    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PAW-1:0]       paddr,
    input  wire logic [CW-1:0]        pwdata,
    output logic [CW-1:0]             prdata,
    output logic                      pready
);

    function automatic logic signed [RW-1:0] sdiff(
        input logic signed [CW-1:0] a,
        input logic signed [CW-1:0] b
    );
        return RW'(a) - RW'(b);
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic signed [CW-1:0] r_left, r_right, r_bottom, r_top;
    logic                 cfg_wr;
    logic [1:0]           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[PAW-1:ADDR_LSB];

    // Write one register per access
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_right  <= COORD_ONE;
            r_bottom <= '0;
            r_top    <= COORD_ONE;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_LEFT:   r_left   <= pwdata;
                REG_RIGHT:  r_right  <= pwdata;
                REG_BOTTOM: r_bottom <= pwdata;
                REG_TOP:    r_top    <= pwdata;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (cfg_idx)
            REG_LEFT:   prdata = r_left;
            REG_RIGHT:  prdata = r_right;
            REG_BOTTOM: prdata = r_bottom;
            REG_TOP:    prdata = r_top;
        endcase
    end

    // ---------------------------------------------------------------
    // Pipeline enable: hold everything while a result waits stalled
    // ---------------------------------------------------------------
    logic r_out_valid;
    logic en;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    // ---------------------------------------------------------------
    // Stage 1: per-side offsets and edge lengths
    // Each side is seen in its own frame: u is the axis across the side,
    // v the axis along it. ca is the plane offset along u, cb the start
    // offset along v, e the signed edge length.
    // ---------------------------------------------------------------
    logic                 r1_v;
    t_ray                 r1_ray;
    logic signed [RW-1:0] r1_ca [NSIDE];
    logic signed [RW-1:0] r1_cb [NSIDE];
    logic signed [RW-1:0] r1_e  [NSIDE];
    logic signed [RW-1:0] s1_ca [NSIDE];
    logic signed [RW-1:0] s1_cb [NSIDE];
    logic signed [RW-1:0] s1_e  [NSIDE];

    always_comb begin
        s1_ca[SIDE_BOTTOM] = sdiff(r_bottom, i_origin_y);
        s1_cb[SIDE_BOTTOM] = sdiff(r_left,   i_origin_x);
        s1_e [SIDE_BOTTOM] = sdiff(r_right,  r_left);
        s1_ca[SIDE_RIGHT]  = sdiff(r_right,  i_origin_x);
        s1_cb[SIDE_RIGHT]  = sdiff(r_bottom, i_origin_y);
        s1_e [SIDE_RIGHT]  = sdiff(r_top,    r_bottom);
        s1_ca[SIDE_TOP]    = sdiff(r_top,    i_origin_y);
        s1_cb[SIDE_TOP]    = sdiff(r_right,  i_origin_x);
        s1_e [SIDE_TOP]    = sdiff(r_left,   r_right);
        s1_ca[SIDE_LEFT]   = sdiff(r_left,   i_origin_x);
        s1_cb[SIDE_LEFT]   = sdiff(r_top,    i_origin_y);
        s1_e [SIDE_LEFT]   = sdiff(r_bottom, r_top);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ray.ox <= i_origin_x;
            r1_ray.oy <= i_origin_y;
            r1_ray.dx <= i_dir_x;
            r1_ray.dy <= i_dir_y;
            for (int k = 0; k < NSIDE; k++) begin
                r1_ca[k] <= s1_ca[k];
                r1_cb[k] <= s1_cb[k];
                r1_e[k]  <= s1_e[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: products and the t > 0 test
    // det = du*e, s numerator = dv*ca - du*cb (vertical sides flip both
    // signs, which leaves the tests unchanged)
    // ---------------------------------------------------------------
    logic                 r2_v;
    t_ray                 r2_ray;
    logic signed [PW-1:0] r2_p1  [NSIDE];
    logic signed [PW-1:0] r2_p2  [NSIDE];
    logic signed [PW-1:0] r2_pd  [NSIDE];
    logic [NSIDE-1:0]     r2_tok;
    logic signed [CW-1:0] s2_du  [NSIDE];
    logic signed [CW-1:0] s2_dv  [NSIDE];

    always_comb begin
        for (int k = 0; k < NSIDE; k++) begin
            s2_du[k] = k[0] ? r1_ray.dx : r1_ray.dy;
            s2_dv[k] = k[0] ? r1_ray.dy : r1_ray.dx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ray <= r1_ray;
            for (int k = 0; k < NSIDE; k++) begin
                r2_p1[k]  <= PW'(s2_dv[k]) * PW'(r1_ca[k]);
                r2_p2[k]  <= PW'(s2_du[k]) * PW'(r1_cb[k]);
                r2_pd[k]  <= PW'(s2_du[k]) * PW'(r1_e[k]);
                r2_tok[k] <= (s2_du[k] != '0) && (r1_e[k] != '0) && (r1_ca[k] != '0)
                             && (r1_ca[k][RW-1] == s2_du[k][CW-1]);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: s numerator, sign-normalized against det
    // ---------------------------------------------------------------
    logic                 r3_v;
    t_ray                 r3_ray;
    logic signed [PW-1:0] r3_p1   [NSIDE];
    logic signed [SW-1:0] r3_sg   [NSIDE];
    logic signed [SW-1:0] r3_adet [NSIDE];
    logic [NSIDE-1:0]     r3_tok;
    logic signed [SW-1:0] s3_sn   [NSIDE];
    logic signed [SW-1:0] s3_det  [NSIDE];

    always_comb begin
        for (int k = 0; k < NSIDE; k++) begin
            s3_sn[k]  = SW'(r2_p1[k]) - SW'(r2_p2[k]);
            s3_det[k] = SW'(r2_pd[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ray <= r2_ray;
            r3_tok <= r2_tok;
            for (int k = 0; k < NSIDE; k++) begin
                r3_p1[k]   <= r2_p1[k];
                r3_sg[k]   <= r2_pd[k][PW-1] ? -s3_sn[k]  : s3_sn[k];
                r3_adet[k] <= r2_pd[k][PW-1] ? -s3_det[k] : s3_det[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: 0 <= s <= 1
    // ---------------------------------------------------------------
    logic                 r4_v;
    t_ray                 r4_ray;
    logic signed [PW-1:0] r4_p1 [NSIDE];
    logic [NSIDE-1:0]     r4_ok;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_ray <= r3_ray;
            for (int k = 0; k < NSIDE; k++) begin
                r4_p1[k] <= r3_p1[k];
                r4_ok[k] <= r3_tok[k] && !r3_sg[k][SW-1] && (r3_sg[k] <= r3_adet[k]);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: pick the first qualifying side
    // ---------------------------------------------------------------
    logic                 r5_v;
    logic signed [PW-1:0] r5_n;
    logic signed [CW-1:0] r5_d;
    t_res_info            r5_info;
    logic                 s5_hit;
    logic [1:0]           s5_side;
    t_res_info            s5_info;

    always_comb begin
        s5_hit  = 1'b1;
        s5_side = SIDE_BOTTOM;
        priority if (r4_ok[SIDE_BOTTOM]) begin
            s5_side = SIDE_BOTTOM;
        end else if (r4_ok[SIDE_RIGHT]) begin
            s5_side = SIDE_RIGHT;
        end else if (r4_ok[SIDE_TOP]) begin
            s5_side = SIDE_TOP;
        end else if (r4_ok[SIDE_LEFT]) begin
            s5_side = SIDE_LEFT;
        end else begin
            s5_hit = 1'b0;
        end

        s5_info.hit  = s5_hit;
        s5_info.side = s5_side;
        s5_info.neg  = 1'b0;
        s5_info.base = s5_side[0] ? r4_ray.oy : r4_ray.ox;
        unique case (s5_side)
            SIDE_BOTTOM: s5_info.plane = r_bottom;
            SIDE_RIGHT:  s5_info.plane = r_right;
            SIDE_TOP:    s5_info.plane = r_top;
            SIDE_LEFT:   s5_info.plane = r_left;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_n    <= r4_p1[s5_side];
            r5_d    <= s5_side[0] ? r4_ray.dx : r4_ray.dy;
            r5_info <= s5_info;
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: set up floor((2n + d) / 2d) with a positive divisor
    // A negative dividend m is divided as ~m and the quotient inverted.
    // ---------------------------------------------------------------
    logic signed [SW-1:0] s6_n;
    logic signed [RW-1:0] s6_d;
    logic signed [SW-1:0] s6_m;
    logic [SW-1:0]        s6_a;
    t_res_info            s6_info;

    always_comb begin
        s6_n = r5_d[CW-1] ? -SW'(r5_n) : SW'(r5_n);
        s6_d = r5_d[CW-1] ? -RW'(r5_d) : RW'(r5_d);
        s6_m = (s6_n <<< 1) + SW'(s6_d);
        s6_a = s6_m[SW-1] ? ~s6_m : s6_m;
        s6_info     = r5_info;
        s6_info.neg = s6_m[SW-1];
    end

    // ---------------------------------------------------------------
    // Divider: one quotient bit per stage; entry 0 is the setup stage
    // ---------------------------------------------------------------
    logic              rd_v    [QW+1];
    logic [RW-1:0]     rd_rem  [QW+1];
    logic [QW-1:0]     rd_low  [QW+1];
    logic [QW-1:0]     rd_q    [QW+1];
    logic [RW-1:0]     rd_dv   [QW+1];
    t_res_info         rd_info [QW+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            rd_rem[0]  <= s6_a[SW-1:QW];
            rd_low[0]  <= s6_a[QW-1:0];
            rd_q[0]    <= '0;
            rd_dv[0]   <= RW'(s6_d) << 1;
            rd_info[0] <= s6_info;
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_div
        logic [RW:0] trial;
        logic        fits;

        assign trial = {rd_rem[j], rd_low[j][QW-1]};
        assign fits  = trial >= {1'b0, rd_dv[j]};

        // Shift in the next dividend bit and subtract when it fits
        always_ff @(posedge i_clk) begin
            if (en) begin
                rd_rem[j+1]  <= fits ? RW'(trial - {1'b0, rd_dv[j]}) : RW'(trial);
                rd_low[j+1]  <= rd_low[j] << 1;
                rd_q[j+1]    <= {rd_q[j][QW-2:0], fits};
                rd_dv[j+1]   <= rd_dv[j];
                rd_info[j+1] <= rd_info[j];
            end
        end
    end

    // ---------------------------------------------------------------
    // Valid bits for every stage
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            for (int j = 0; j <= QW; j++) begin
                rd_v[j] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_v    <= i_valid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r4_v    <= r3_v;
            r5_v    <= r4_v;
            rd_v[0] <= r5_v;
            for (int j = 0; j < QW; j++) begin
                rd_v[j+1] <= rd_v[j];
            end
            r_out_valid <= rd_v[QW];
        end
    end

    // ---------------------------------------------------------------
    // Output register: add the rounded offset to the origin
    // ---------------------------------------------------------------
    logic                 r_hit;
    logic signed [CW-1:0] r_hit_x, r_hit_y;
    logic [1:0]           r_hit_side;
    logic [QW:0]          so_q;
    logic signed [CW-1:0] so_sum;
    t_res_info            so_info;

    always_comb begin
        so_info = rd_info[QW];
        so_q    = so_info.neg ? ~{1'b0, rd_q[QW]} : {1'b0, rd_q[QW]};
        so_sum  = so_info.base + CW'(so_q);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit      <= so_info.hit;
            r_hit_side <= so_info.hit ? so_info.side : SIDE_BOTTOM;
            if (!so_info.hit) begin
                r_hit_x <= '0;
                r_hit_y <= '0;
            end else if (so_info.side[0]) begin
                r_hit_x <= so_info.plane;
                r_hit_y <= so_sum;
            end else begin
                r_hit_x <= so_sum;
                r_hit_y <= so_info.plane;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_hit      = r_hit;
    assign o_hit_x    = r_hit_x;
    assign o_hit_y    = r_hit_y;
    assign o_hit_side = r_hit_side;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_hit_x == '0 && o_hit_y == '0 && o_hit_side == SIDE_BOTTOM))
        else $error("miss result carries nonzero fields");

    a_bottom_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit && o_hit_side == SIDE_BOTTOM) |-> (o_hit_y == r_bottom))
        else $error("bottom hit off the bottom edge");

    a_right_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit && o_hit_side == SIDE_RIGHT) |-> (o_hit_x == r_right))
        else $error("right hit off the right edge");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result waiting");

endmodule
`default_nettype wire
